/* hdl/oelr_pkg.sv */
// Package for the overwriting event log ring.
// Holds the item kinds, the request, response and entry word types and default sizes.
// Depends on nothing.
package oelr_pkg;

   localparam int LOG_DEPTH_DEF = 32;
   localparam int HELD_W        = 8;
   localparam int INDEX_W       = 8;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [3:0]          event_code;
      logic [2:0]          alarm_lvl;
      logic [7:0]          source_bits;
      logic [3:0]          system_mode;
      logic [15:0]         light_millivolts;
      logic [15:0]         gas_millivolts;
      logic signed [7:0]   temperature;
      logic [7:0]          humidity;
      logic [INDEX_W-1:0]  read_index;
   } req_word_type;

   typedef struct packed {
      logic                found;
      logic [31:0]         stamp_seconds;
      logic [3:0]          out_event;
      logic [2:0]          out_level;
      logic [7:0]          out_sources;
      logic [3:0]          out_mode;
      logic [15:0]         out_light;
      logic [15:0]         out_gas;
      logic signed [7:0]   out_temperature;
      logic [7:0]          out_humidity;
      logic [HELD_W-1:0]   entries_held;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0]         stamp;
      logic [15:0]         light;
      logic [15:0]         gas;
      logic [3:0]          code;
      logic [2:0]          level;
      logic [7:0]          sources;
      logic [3:0]          mode;
      logic signed [7:0]   temp;
      logic [7:0]          humid;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_cmd_type;

endpackage

/* hdl/oelr_ram.sv */
// Entry memory of the event log: one write port and one read port.
// The read data is registered.
// Depends on oelr_pkg.
module oelr_ram #(
   parameter int LOG_DEPTH = oelr_pkg::LOG_DEPTH_DEF,
   parameter int SW        = $clog2(LOG_DEPTH)
) (
   input  logic                  clock,
   input  oelr_pkg::ram_cmd_type cmd,
   input  logic [SW-1:0]         wr_addr,
   input  oelr_pkg::entry_type   wr_data,
   input  logic [SW-1:0]         rd_addr,
   output oelr_pkg::entry_type   rd_data
);
   import oelr_pkg::*;

   entry_type mem_ff [LOG_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/oelr_ctrl.sv */
// Control of the event log: write slot, entry count, seconds counter,
// read address arithmetic and the response stage.
// Depends on oelr_pkg.
module oelr_ctrl #(
   parameter int LOG_DEPTH = oelr_pkg::LOG_DEPTH_DEF,
   parameter int SW        = $clog2(LOG_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  oelr_pkg::req_word_type req,
   output oelr_pkg::ram_cmd_type  ram_cmd,
   output logic [SW-1:0]          wr_addr,
   output oelr_pkg::entry_type    wr_data,
   output logic [SW-1:0]          rd_addr,
   input  oelr_pkg::entry_type    rd_data,
   output logic                   rsp_strobe,
   output oelr_pkg::rsp_word_type rsp_word
);
   import oelr_pkg::*;

   localparam int CW = $clog2(LOG_DEPTH + 1);
   localparam int AW = CW + 2;

   logic [SW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [31:0]       seconds_ff, seconds_in;
   logic              strobe_ff, strobe_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     held_ff, held_in;
   logic              hit;
   logic [AW-1:0]     pos_sum;
   logic [AW-1:0]     pos_wrap;

   always_comb begin
      hit     = ({{(HELD_W - CW){1'b0}}, count_ff} > req.read_index);
      pos_sum = AW'(slot_ff) + AW'(LOG_DEPTH) + AW'(req.read_index[CW-1:0])
                - AW'(count_ff);
      if (pos_sum >= AW'(LOG_DEPTH)) begin
         pos_wrap = pos_sum - AW'(LOG_DEPTH);
      end else begin
         pos_wrap = pos_sum;
      end
   end

   always_comb begin
      slot_in       = slot_ff;
      count_in      = count_ff;
      seconds_in    = seconds_ff;
      strobe_in     = accept;
      found_in      = 1'b0;
      ram_cmd.wr_en = 1'b0;
      ram_cmd.rd_en = 1'b0;
      if (accept) begin
         case (req.kind)
            KIND_ADD: begin
               ram_cmd.wr_en = 1'b1;
               if (slot_ff == SW'(LOG_DEPTH - 1)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + SW'(1);
               end
               if (count_ff != CW'(LOG_DEPTH)) begin
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_READ: begin
               ram_cmd.rd_en = hit;
               found_in      = hit;
            end
            KIND_CLEAR: begin
               slot_in  = '0;
               count_in = '0;
            end
            KIND_TICK: begin
               seconds_in = seconds_ff + 32'd1;
            end
            default: begin
               slot_in = slot_ff;
            end
         endcase
      end
      held_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         count_ff   <= '0;
         seconds_ff <= '0;
         strobe_ff  <= 1'b0;
         found_ff   <= 1'b0;
         held_ff    <= '0;
      end else begin
         slot_ff    <= slot_in;
         count_ff   <= count_in;
         seconds_ff <= seconds_in;
         strobe_ff  <= strobe_in;
         found_ff   <= found_in;
         held_ff    <= held_in;
      end
   end

   assign wr_addr = slot_ff;
   assign rd_addr = pos_wrap[SW-1:0];

   always_comb begin
      wr_data.stamp   = seconds_ff;
      wr_data.light   = req.light_millivolts;
      wr_data.gas     = req.gas_millivolts;
      wr_data.code    = req.event_code;
      wr_data.level   = req.alarm_lvl;
      wr_data.sources = req.source_bits;
      wr_data.mode    = req.system_mode;
      wr_data.temp    = req.temperature;
      wr_data.humid   = req.humidity;
   end

   always_comb begin
      rsp_word = '0;
      rsp_word.entries_held = {{(HELD_W - CW){1'b0}}, held_ff};
      if (found_ff) begin
         rsp_word.found           = 1'b1;
         rsp_word.stamp_seconds   = rd_data.stamp;
         rsp_word.out_event       = rd_data.code;
         rsp_word.out_level       = rd_data.level;
         rsp_word.out_sources     = rd_data.sources;
         rsp_word.out_mode        = rd_data.mode;
         rsp_word.out_light       = rd_data.light;
         rsp_word.out_gas         = rd_data.gas;
         rsp_word.out_temperature = rd_data.temp;
         rsp_word.out_humidity    = rd_data.humid;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

/* hdl/overwriting_event_log_ring.sv */
// Top level of the overwriting event log ring.
// Instantiates the control block and the entry memory; depends on oelr_pkg.
//
// A new word may be started on every clock cycle: busy stays low, and the
// response to each word appears in the cycle after it was taken, on
// rsp_strobe for one cycle, with no way for the receiver to hold it off.
// The read data comes from the registered read port of the
// entry memory; an add followed at once by a read of the same entry
// returns the new contents, as the write lands before the next read.
module overwriting_event_log_ring #(
   parameter int LOG_DEPTH = oelr_pkg::LOG_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  oelr_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output oelr_pkg::rsp_word_type rsp_word
);
   import oelr_pkg::*;

   localparam int SW = $clog2(LOG_DEPTH);

   ram_cmd_type   ram_cmd;
   logic [SW-1:0] wr_addr;
   logic [SW-1:0] rd_addr;
   entry_type     wr_data;
   entry_type     rd_data;
   logic          accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   oelr_ctrl #(
      .LOG_DEPTH (LOG_DEPTH),
      .SW        (SW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_word),
      .ram_cmd    (ram_cmd),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   oelr_ram #(
      .LOG_DEPTH (LOG_DEPTH),
      .SW        (SW)
   ) u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
